// ===== src/pcmp_pkg.sv =====
// Shared types, constants and a helper function for the PNG chunk metadata parser.
package pcmp_pkg;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_TYPE = 3'd2,
      PH_DATA = 3'd3,
      PH_CRC  = 3'd4,
      PH_DONE = 3'd5,
      PH_DEAD = 3'd6
   } pcmp_phase_type;

   typedef enum logic [2:0] {
      EV_HEADER   = 3'd0,
      EV_KEYWORD  = 3'd1,
      EV_TEXT     = 3'd2,
      EV_ENTRY    = 3'd3,
      EV_NOT_PNG  = 3'd4,
      EV_END      = 3'd5
   } pcmp_event_type;

   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   // One word as it sits in the input register.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } pcmp_word_type;

   // One result as produced by the parser; hit marks that a result exists.
   typedef struct packed {
      logic           hit;
      pcmp_event_type kind;
      logic [31:0]    image_width;
      logic [31:0]    image_height;
      logic [7:0]     bit_depth;
      logic [7:0]     color_kind;
      logic [7:0]     char_byte;
   } pcmp_result_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'd137;
         3'd1:    val = 8'd80;
         3'd2:    val = 8'd78;
         3'd3:    val = 8'd71;
         3'd4:    val = 8'd13;
         3'd5:    val = 8'd10;
         3'd6:    val = 8'd26;
         3'd7:    val = 8'd10;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/pcmp_in_reg.sv =====
// Input register stage that holds one incoming word until the parser takes it.
module pcmp_in_reg
   import pcmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,
   input  logic          req_file_start,
   input  logic          advance,
   output logic          held_valid,
   output pcmp_word_type held_word
);

   logic          valid_ff;
   logic          valid_in;
   pcmp_word_type word_ff;

   assign req_ready  = !valid_ff || advance;
   assign held_valid = valid_ff;
   assign held_word  = word_ff;

   always_comb begin
      if (req_ready) begin
         valid_in = req_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         word_ff <= '{data_byte: req_data_byte, file_start: req_file_start};
      end
   end

endmodule

// ===== src/pcmp_parser.sv =====
// Per-byte parse state and the combinational next-state and result logic.
module pcmp_parser
   import pcmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  pcmp_word_type   word,
   output pcmp_result_type result
);

   pcmp_phase_type phase_ff, phase_in, phase_cur;
   logic [31:0]    count_ff, count_in, count_cur;
   logic           sig_ok_ff, sig_ok_in, sig_ok_cur;
   logic [31:0]    len_ff, len_in, len_cur;
   logic [31:0]    ctype_ff, ctype_in, ctype_cur;
   logic [31:0]    width_ff, width_in, width_cur;
   logic [31:0]    height_ff, height_in, height_cur;
   logic [7:0]     depth_ff, depth_in, depth_cur;
   logic [7:0]     color_ff, color_in, color_cur;
   logic           keyword_ff, keyword_in, keyword_cur;
   logic [31:0]    count_next;
   logic [7:0]     b;

   assign b          = word.data_byte;
   assign count_next = count_cur + 32'd1;

   always_comb begin
      // A file start restarts the parser before this byte is looked at.
      if (word.file_start) begin
         phase_cur   = PH_SIG;
         count_cur   = '0;
         sig_ok_cur  = 1'b1;
         len_cur     = '0;
         ctype_cur   = '0;
         width_cur   = '0;
         height_cur  = '0;
         depth_cur   = '0;
         color_cur   = '0;
         keyword_cur = 1'b1;
      end else begin
         phase_cur   = phase_ff;
         count_cur   = count_ff;
         sig_ok_cur  = sig_ok_ff;
         len_cur     = len_ff;
         ctype_cur   = ctype_ff;
         width_cur   = width_ff;
         height_cur  = height_ff;
         depth_cur   = depth_ff;
         color_cur   = color_ff;
         keyword_cur = keyword_ff;
      end

      phase_in   = phase_cur;
      count_in   = count_cur;
      sig_ok_in  = sig_ok_cur;
      len_in     = len_cur;
      ctype_in   = ctype_cur;
      width_in   = width_cur;
      height_in  = height_cur;
      depth_in   = depth_cur;
      color_in   = color_cur;
      keyword_in = keyword_cur;
      result     = '0;

      case (phase_cur)
         PH_SIG: begin
            if (b != sig_byte(count_cur[2:0])) begin
               sig_ok_in = 1'b0;
            end
            if (count_cur[2:0] == 3'd7) begin
               count_in = '0;
               if (sig_ok_in) begin
                  phase_in = PH_LEN;
                  len_in   = '0;
               end else begin
                  phase_in    = PH_DEAD;
                  result.hit  = 1'b1;
                  result.kind = EV_NOT_PNG;
               end
            end else begin
               count_in = {29'd0, count_cur[2:0]} + 32'd1;
            end
         end
         PH_LEN: begin
            len_in   = {len_cur[23:0], b};
            count_in = count_next;
            if (count_next >= 32'd4) begin
               count_in = '0;
               ctype_in = '0;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            ctype_in = {ctype_cur[23:0], b};
            count_in = count_next;
            if (count_next >= 32'd4) begin
               count_in   = '0;
               width_in   = '0;
               height_in  = '0;
               depth_in   = '0;
               color_in   = '0;
               keyword_in = 1'b1;
               phase_in   = (len_cur == '0) ? PH_CRC : PH_DATA;
            end
         end
         PH_DATA: begin
            if (ctype_cur == TYPE_IHDR) begin
               // Fields were cleared at the type, so a byte simply lands in its slot.
               if (count_cur[31:4] == '0) begin
                  case (count_cur[3:0])
                     4'd0:    width_in[31:24]  = b;
                     4'd1:    width_in[23:16]  = b;
                     4'd2:    width_in[15:8]   = b;
                     4'd3:    width_in[7:0]    = b;
                     4'd4:    height_in[31:24] = b;
                     4'd5:    height_in[23:16] = b;
                     4'd6:    height_in[15:8]  = b;
                     4'd7:    height_in[7:0]   = b;
                     4'd8:    depth_in         = b;
                     4'd9:    color_in         = b;
                     default: ;
                  endcase
               end
            end else if (ctype_cur == TYPE_TEXT) begin
               if (keyword_cur) begin
                  if (b == 8'd0) begin
                     keyword_in = 1'b0;
                  end else begin
                     result.hit       = 1'b1;
                     result.kind      = EV_KEYWORD;
                     result.char_byte = b;
                  end
               end else begin
                  result.hit       = 1'b1;
                  result.kind      = EV_TEXT;
                  result.char_byte = b;
               end
            end
            if (count_next >= len_cur) begin
               count_in = '0;
               phase_in = PH_CRC;
            end else begin
               count_in = count_next;
            end
         end
         PH_CRC: begin
            count_in = count_next;
            if (count_next >= 32'd4) begin
               count_in = '0;
               len_in   = '0;
               phase_in = PH_LEN;
               if (ctype_cur == TYPE_IHDR) begin
                  result.hit          = 1'b1;
                  result.kind         = EV_HEADER;
                  result.image_width  = width_cur;
                  result.image_height = height_cur;
                  result.bit_depth    = depth_cur;
                  result.color_kind   = color_cur;
               end else if (ctype_cur == TYPE_TEXT) begin
                  result.hit  = 1'b1;
                  result.kind = EV_ENTRY;
               end else if (ctype_cur == TYPE_IEND) begin
                  phase_in    = PH_DONE;
                  result.hit  = 1'b1;
                  result.kind = EV_END;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIG;
         count_ff   <= '0;
         sig_ok_ff  <= 1'b1;
         len_ff     <= '0;
         ctype_ff   <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         color_ff   <= '0;
         keyword_ff <= 1'b1;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         sig_ok_ff  <= sig_ok_in;
         len_ff     <= len_in;
         ctype_ff   <= ctype_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         color_ff   <= color_in;
         keyword_ff <= keyword_in;
      end
   end

endmodule

// ===== src/png_chunk_metadata_parser.sv =====
// Top level of the PNG chunk metadata parser: input register, parser and result register.
//
// The block takes a PNG file one word (one byte) at a time on the req_ channel and
// reports metadata events on the rsp_ channel. Both channels use valid and ready.
// A word with req_file_start high restarts parsing at the signature.
// Each accepted word is first captured in an input register; once the result register
// is free, the parser updates its state from it and, if the word causes an event, loads
// the result register. Most words cause no event and simply leave the input register.
// Throughput is one word per cycle: the input and result registers both advance in
// the same cycle whenever the result register is empty or being read out.
// If the receiver holds rsp_ready low with a result waiting, the input register takes a
// word only while empty; once it holds one, req_ready stays low until the result is taken.
// Synchronous reset empties both registers and puts the parser back at the start of
// the signature, as if a file start had been seen.
// The chunk CRC is not checked. After a bad signature or after IEND, all words are
// consumed silently until the next file start.
module png_chunk_metadata_parser
   import pcmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height,
   output logic [7:0]  rsp_bit_depth,
   output logic [7:0]  rsp_color_kind,
   output logic [7:0]  rsp_char_byte
);

   logic            out_free;
   logic            held_valid;
   pcmp_word_type   held_word;
   logic            step;
   pcmp_result_type result;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   pcmp_result_type rsp_ff;

   // The result register can take a new value when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = held_valid && out_free;

   pcmp_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_file_start (req_file_start),
      .advance        (out_free),
      .held_valid     (held_valid),
      .held_word      (held_word)
   );

   pcmp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (held_word),
      .result (result)
   );

   always_comb begin
      if (out_free) begin
         rsp_valid_in = step && result.hit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.hit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_ff.kind;
   assign rsp_image_width  = rsp_ff.image_width;
   assign rsp_image_height = rsp_ff.image_height;
   assign rsp_bit_depth    = rsp_ff.bit_depth;
   assign rsp_color_kind   = rsp_ff.color_kind;
   assign rsp_char_byte    = rsp_ff.char_byte;

endmodule
